>>> src/vps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types and constants for the vibration pattern sequencer.
// ----------------------------------------------------------------------------
package vps_pkg;

    // default sizes
    localparam int NUM_PATTERNS_DEF      = 8;
    localparam int STEPS_PER_PATTERN_DEF = 16;
    localparam int DURATION_BITS_DEF     = 16;

    // item kind codes
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // result action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  pattern;
        logic [3:0]  step;
        logic [15:0] duration;
        logic [7:0]  flag;
        logic [7:0]  power;
        logic [7:0]  freq;
    } in_item_t;

    typedef struct packed {
        logic       action;
        logic [7:0] out_flag;
        logic [7:0] out_power;
        logic [7:0] out_freq;
        logic       last;
    } out_item_t;

endpackage
`default_nettype wire

>>> src/vibration_pattern_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer
// Plays haptic vibration patterns from a loadable step table on timer ticks.
// ----------------------------------------------------------------------------
// flow: an accepted item is registered in the input register and processed
//   from there; its results enter the output queue at the edge on which it fires
// throughput: one item per cycle while the result queue has room; a tick with
//   two results waits until the two-entry queue behind the single output port can take both
// reset: sequencer goes idle at once, the step table is undefined until loaded
module vibration_pattern_sequencer #(
    parameter int NUM_PATTERNS      = vps_pkg::NUM_PATTERNS_DEF,
    parameter int STEPS_PER_PATTERN = vps_pkg::STEPS_PER_PATTERN_DEF,
    parameter int DURATION_BITS     = vps_pkg::DURATION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_stall,
    input  wire vps_pkg::in_item_t src_item,
    output logic                   cmd_valid,
    input  wire logic              cmd_stall,
    output vps_pkg::out_item_t     cmd_item
);
    import vps_pkg::*;

    // sizes derived from the parameters
    localparam int PW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int SIW   = $clog2(STEPS_PER_PATTERN + 1);
    localparam int TW    = DURATION_BITS + 1;
    localparam int DEPTH = NUM_PATTERNS * STEPS_PER_PATTERN;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = DURATION_BITS + 24;

    localparam logic [PW-1:0]  IDLE_PAT  = PW'(NUM_PATTERNS - 1);
    localparam logic [SIW-1:0] STEP_LIM  = SIW'(STEPS_PER_PATTERN);
    localparam logic [SIW-1:0] STEP_LAST = SIW'(STEPS_PER_PATTERN - 1);
    localparam logic [TW-1:0]  TICK_MAX  = {TW{1'b1}};

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // sequencer state
    logic [PW-1:0]  cur_reg,     cur_next;
    logic [SIW-1:0] step_reg,    step_next;
    logic [TW-1:0]  tick_reg,    tick_next;
    logic           running_reg, running_next;

    // step table and its prefetched entries: previous step and next step of
    // the state the sequencer holds after each edge
    logic [EW-1:0] table_mem [DEPTH];
    logic [EW-1:0] rd_prev_reg;
    logic [EW-1:0] rd_cur_reg;

    // result queue, entry 0 is the head
    out_item_t q_reg [2];
    logic [1:0] q_cnt_reg;

    // processing signals
    logic           fire;
    logic [1:0]     n_res;
    out_item_t      res0, res1;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;
    logic [AW-1:0]  rd_prev_addr, rd_cur_addr;
    logic [SIW-1:0] idx_prev, idx_cur;
    logic           pop;
    logic [1:0]     cnt_eff;

    logic [DURATION_BITS-1:0] dur_prev, dur_cur;
    logic [PW-1:0]  c_cur;
    logic [SIW-1:0] c_step;
    logic [TW-1:0]  c_tick;
    logic           c_run;
    logic           pat_ok, load_ok;

    assign dur_prev = rd_prev_reg[EW-1:24];
    assign dur_cur  = rd_cur_reg[EW-1:24];

    assign pat_ok  = {1'b0, in_item_reg.pattern} < 5'(NUM_PATTERNS);
    assign load_ok = pat_ok && ({5'b0, in_item_reg.step} < 9'(STEPS_PER_PATTERN));

    assign wr_addr = AW'(in_item_reg.pattern) * AW'(STEPS_PER_PATTERN)
                   + AW'(in_item_reg.step);
    assign wr_data = {DURATION_BITS'(in_item_reg.duration), in_item_reg.flag,
                      in_item_reg.power, in_item_reg.freq};

    // one item of work: decode, step the sequencer and form its results
    always_comb
    begin
        c_cur  = cur_reg;
        c_step = step_reg;
        c_tick = tick_reg;
        c_run  = running_reg;
        n_res  = 2'd0;
        res0   = '0;
        res1   = '0;
        wr_en  = 1'b0;
        case (in_item_reg.kind)
            KIND_LOAD:
            begin
                wr_en = load_ok;
            end
            KIND_REQUEST:
            begin
                if (pat_ok)
                begin
                    if (running_reg)
                    begin
                        // while running only a higher pattern takes over
                        if ({1'b0, in_item_reg.pattern} > 5'(cur_reg))
                        begin
                            c_cur = PW'(in_item_reg.pattern);
                        end
                    end
                    else
                    begin
                        c_cur  = PW'(in_item_reg.pattern);
                        c_step = '0;
                        c_tick = '0;
                        c_run  = 1'b0;
                    end
                end
            end
            KIND_TICK:
            begin
                if (cur_reg != IDLE_PAT)
                begin
                    if (step_reg == '0)
                    begin
                        // first step starts on the first tick
                        res0.action    = ACT_START;
                        res0.out_flag  = rd_cur_reg[23:16];
                        res0.out_power = rd_cur_reg[15:8];
                        res0.out_freq  = rd_cur_reg[7:0];
                        res0.last      = 1'b1;
                        n_res  = 2'd1;
                        c_step = SIW'(1);
                        c_run  = 1'b1;
                    end
                    else if ({1'b0, dur_prev} < tick_reg)
                    begin
                        c_tick = '0;
                        res0.action = ACT_STOP;
                        if (step_reg >= STEP_LIM || dur_cur == '0)
                        begin
                            // end of pattern: stop and fall back to idle
                            res0.last = 1'b1;
                            n_res  = 2'd1;
                            c_cur  = IDLE_PAT;
                            c_step = '0;
                            c_run  = 1'b0;
                        end
                        else
                        begin
                            res0.last      = 1'b0;
                            res1.action    = ACT_START;
                            res1.out_flag  = rd_cur_reg[23:16];
                            res1.out_power = rd_cur_reg[15:8];
                            res1.out_freq  = rd_cur_reg[7:0];
                            res1.last      = 1'b1;
                            n_res  = 2'd2;
                            c_step = step_reg + SIW'(1);
                        end
                    end
                    // tick count saturates
                    if (c_run && c_tick != TICK_MAX)
                    begin
                        c_tick = c_tick + TW'(1);
                    end
                end
            end
            default:
            begin
                // unused kind, no effect
            end
        endcase
    end

    // result queue room decides whether the held item goes through
    assign pop     = (q_cnt_reg != 2'd0) && !cmd_stall;
    assign cnt_eff = q_cnt_reg - {1'b0, pop};
    assign fire    = in_valid_reg && (({1'b0, cnt_eff} + {1'b0, n_res}) <= 3'd2);

    assign src_stall = in_valid_reg && !fire;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign cmd_item  = q_reg[0];

    assign cur_next     = fire ? c_cur  : cur_reg;
    assign step_next    = fire ? c_step : step_reg;
    assign tick_next    = fire ? c_tick : tick_reg;
    assign running_next = fire ? c_run  : running_reg;

    // prefetch addresses follow the next state, clamped inside the pattern
    assign idx_prev = (step_next == '0) ? '0 : step_next - SIW'(1);
    assign idx_cur  = (step_next >= STEP_LIM) ? STEP_LAST : step_next;
    assign rd_prev_addr = AW'(cur_next) * AW'(STEPS_PER_PATTERN) + AW'(idx_prev);
    assign rd_cur_addr  = AW'(cur_next) * AW'(STEPS_PER_PATTERN) + AW'(idx_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cur_reg      <= IDLE_PAT;
            step_reg     <= '0;
            tick_reg     <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            if (!src_stall)
            begin
                in_valid_reg <= src_valid;
            end
            cur_reg     <= cur_next;
            step_reg    <= step_next;
            tick_reg    <= tick_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!src_stall && src_valid)
        begin
            in_item_reg <= src_item;
        end
    end

    // table write and registered reads with write-through
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (fire && wr_en && wr_addr == rd_prev_addr)
        begin
            rd_prev_reg <= wr_data;
        end
        else
        begin
            rd_prev_reg <= table_mem[rd_prev_addr];
        end
        if (fire && wr_en && wr_addr == rd_cur_addr)
        begin
            rd_cur_reg <= wr_data;
        end
        else
        begin
            rd_cur_reg <= table_mem[rd_cur_addr];
        end
    end

    // result queue: shift on pop, append new results behind what stays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            q_cnt_reg <= fire ? (cnt_eff + n_res) : cnt_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && cnt_eff == 2'd0)
        begin
            q_reg[0] <= res0;
            q_reg[1] <= res1;
        end
        else if (fire && cnt_eff == 2'd1)
        begin
            q_reg[0] <= pop ? q_reg[1] : q_reg[0];
            q_reg[1] <= res0;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
        end
    end

endmodule
`default_nettype wire

>>> bench/vibration_pattern_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer_tb
// Self-checking bench for the haptic pattern sequencer. Items are driven
// through the valid/stall input channel and a bench-side model of the
// step table and play state predicts every start/stop command. The model
// never lets a tick read a table slot that was never loaded.
// ----------------------------------------------------------------------------
module vibration_pattern_sequencer_tb;
    import vps_pkg::*;

    localparam int PATTERNS       = NUM_PATTERNS_DEF;
    localparam int STEPS          = STEPS_PER_PATTERN_DEF;
    localparam int IDLE_PAT       = PATTERNS - 1;
    localparam int PAT_BITS       = $clog2(PATTERNS);
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 780;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_PAD      = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // one table slot as the sequencer sees it
    typedef struct packed {
        logic [15:0] dur;
        logic [7:0]  flag;
        logic [7:0]  power;
        logic [7:0]  freq;
    } step_t;

    logic       clk;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    in_item_t   src_item;
    logic       cmd_valid;
    logic       cmd_stall;
    out_item_t  cmd_item;

    // bench copy of the sequencer state
    step_t                       step_table   [PATTERNS][STEPS];
    bit                          step_written [PATTERNS][STEPS];
    logic [PAT_BITS-1:0]         cur_pat;
    int unsigned                 step_no;
    logic [DURATION_BITS_DEF:0]  ticks_in_step;
    bit                          playing;

    // commands the sequencer still owes us, oldest first
    out_item_t pending_cmds[$];

    // pacing knobs shared by the sender and receiver
    int gap_max;
    int burst_left;
    int stall_pct;
    int hold_req;

    int items_sent;
    int work_items;
    int cmds_checked;
    int patterns_done;
    int mismatches;

    vibration_pattern_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void go_idle();
        cur_pat       = PAT_BITS'(IDLE_PAT);
        step_no       = 0;
        ticks_in_step = '0;
        playing       = 1'b0;
    endfunction

    // stop commands carry zero settings
    function automatic void push_cmd(input logic action, input step_t s, input logic last);
        out_item_t c;
        c.action    = action;
        c.out_flag  = (action == ACT_START) ? s.flag  : 8'h00;
        c.out_power = (action == ACT_START) ? s.power : 8'h00;
        c.out_freq  = (action == ACT_START) ? s.freq  : 8'h00;
        c.last      = last;
        pending_cmds.push_back(c);
    endfunction

    // apply one accepted item to the model and queue the commands it causes
    function automatic void advance_sequencer(input in_item_t it);
        int pat;
        int cur;
        pat = int'(it.pattern);
        cur = int'(cur_pat);
        case (it.kind)
            KIND_LOAD:
            begin
                if (pat < PATTERNS && int'(it.step) < STEPS)
                begin
                    step_table[pat][it.step]   = '{it.duration, it.flag, it.power, it.freq};
                    step_written[pat][it.step] = 1'b1;
                    work_items++;
                end
            end
            KIND_REQUEST:
            begin
                if (pat < PATTERNS)
                begin
                    work_items++;
                    // while playing only a higher number takes over
                    if (playing)
                    begin
                        if (pat > cur)
                            cur_pat = PAT_BITS'(pat);
                    end
                    else
                    begin
                        go_idle();
                        cur_pat = PAT_BITS'(pat);
                    end
                end
            end
            KIND_TICK:
            begin
                work_items++;
                if (cur != IDLE_PAT)
                begin
                    if (step_no == 0)
                    begin
                        push_cmd(ACT_START, step_table[cur][0], 1'b1);
                        step_no = 1;
                        playing = 1'b1;
                    end
                    else if ({1'b0, step_table[cur][step_no - 1].dur} < ticks_in_step)
                    begin
                        ticks_in_step = '0;
                        if (step_no < STEPS && step_table[cur][step_no].dur != 16'd0)
                        begin
                            push_cmd(ACT_STOP, '0, 1'b0);
                            push_cmd(ACT_START, step_table[cur][step_no], 1'b1);
                            step_no++;
                        end
                        else
                        begin
                            // end marker or step limit
                            push_cmd(ACT_STOP, '0, 1'b1);
                            go_idle();
                            patterns_done++;
                        end
                    end
                    if (playing && ticks_in_step != '1)
                        ticks_in_step++;
                end
            end
            default: ;
        endcase
    endfunction

    // slot the next tick would read without it ever being loaded, or -1
    function automatic int unloaded_slot();
        int cur;
        cur = int'(cur_pat);
        if (cur == IDLE_PAT)
            return -1;
        if (step_no == 0)
            return step_written[cur][0] ? -1 : cur * STEPS;
        if (!step_written[cur][step_no - 1])
            return cur * STEPS + step_no - 1;
        if ({1'b0, step_table[cur][step_no - 1].dur} < ticks_in_step && step_no < STEPS
            && !step_written[cur][step_no])
            return cur * STEPS + step_no;
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // mostly short durations so patterns actually progress
    function automatic in_item_t random_item();
        in_item_t it;
        it.kind     = 2'($urandom_range(0, 3));
        it.pattern  = 4'($urandom_range(0, 15));
        it.step     = 4'($urandom_range(0, 15));
        it.duration = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                      : $urandom_range(0, 4));
        it.flag     = 8'($urandom_range(0, 255));
        it.power    = 8'($urandom_range(0, 255));
        it.freq     = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic in_item_t retag(input logic [1:0] kind, input int pat);
        in_item_t it;
        it         = random_item();
        it.kind    = kind;
        it.pattern = 4'(pat);
        return it;
    endfunction

    function automatic void set_pacing(input bit calm);
        gap_max   = calm ? 0 : $urandom_range(2, 8);
        stall_pct = calm ? 0 : $urandom_range(10, 60);
    endfunction

    // offer one item in bursts with random gaps, update the model on accept
    task automatic send_item(input in_item_t it);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        items_sent++;
        advance_sequencer(it);
    endtask

    task automatic src_release();
        @(negedge clk);
        src_valid <= 1'b0;
    endtask

    task automatic send_load(input int pat, input int stp, input int dur,
                             input int fl, input int pw, input int fr);
        in_item_t it;
        it          = retag(KIND_LOAD, pat);
        it.step     = 4'(stp);
        it.duration = 16'(dur);
        it.flag     = 8'(fl);
        it.power    = 8'(pw);
        it.freq     = 8'(fr);
        send_item(it);
    endtask

    task automatic send_request(input int pat);
        send_item(retag(KIND_REQUEST, pat));
    endtask

    // a tick, preceded by loads of any slot it would otherwise read unloaded
    task automatic send_tick();
        int slot;
        slot = unloaded_slot();
        while (slot >= 0)
        begin
            send_load(slot / STEPS, slot % STEPS,
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            slot = unloaded_slot();
        end
        send_item(retag(KIND_TICK, $urandom_range(0, 15)));
    endtask

    // n steps of random settings, then an end marker unless the table is full
    task automatic load_pattern(input int pat, input int n, input int max_dur);
        for (int s = 0; s < n; s++)
            send_load(pat, s, $urandom_range(1, max_dur),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        if (n < STEPS)
            send_load(pat, n, 0,
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic play_out(input int limit);
        int n;
        n = 0;
        while (playing && n < limit)
        begin
            send_tick();
            n++;
        end
    endtask

    task automatic drain();
        src_release();
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // idle ticks, unused kind and out-of-range requests all stay silent
    task automatic test_idle_after_reset();
        set_pacing(1'b1);
        send_tick();
        send_item(retag(KIND_UNUSED, 0));
        send_request(PATTERNS);
        send_request(15);
        send_tick();
        drain();
    endtask

    // short pattern with extreme settings; loads beyond the table ignored
    task automatic test_basic_pattern();
        set_pacing(1'b0);
        send_load(0, 0, 1, 8'hFF, 8'hFF, 8'hFF);
        send_load(0, 1, 2, 8'h00, 8'h00, 8'h00);
        send_load(0, 2, 0, 8'h5A, 8'hA5, 8'h3C);
        send_load(PATTERNS, 0, 3, 8'h11, 8'h22, 8'h33);
        send_load(15, 15, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(0);
        play_out(20);
        drain();
    endtask

    // a higher request takes over mid-play, lower and out-of-range do not
    task automatic test_replace();
        set_pacing(1'b0);
        load_pattern(2, 2, 1);
        load_pattern(5, 3, 2);
        send_request(2);
        send_tick();
        send_tick();
        send_request(5);
        send_request(4);
        send_request(12);
        play_out(40);
        drain();
    endtask

    // longest duration holds the step; shortening it live lets it finish
    task automatic test_long_step();
        set_pacing(1'b1);
        send_load(IDLE_PAT - 1, 0, 16'hFFFF, 8'hC3, 8'h3C, 8'h81);
        send_load(IDLE_PAT - 1, 1, 0, 8'h00, 8'h00, 8'h00);
        send_request(IDLE_PAT - 1);
        repeat (6) send_tick();
        send_load(IDLE_PAT - 1, 0, 1, 8'hC3, 8'h3C, 8'h81);
        play_out(4);
        drain();
    endtask

    // full-length pattern against a long receiver hold, input backs up
    task automatic test_backpressure();
        gap_max   = 0;
        stall_pct = 0;
        load_pattern(3, STEPS, 1);
        hold_req++;
        repeat (60)
        begin
            if (!playing)
                send_request(3);
            send_tick();
        end
        drain();
    endtask

    // mostly well-formed play sequences, the rest noise
    task automatic test_random_traffic();
        int goal;
        int next_pace;
        int pat;
        in_item_t it;
        goal      = items_sent + RANDOM_ITEMS;
        next_pace = 0;
        while (items_sent < goal)
        begin
            if (items_sent >= next_pace)
            begin
                set_pacing($urandom_range(0, 3) == 0);
                next_pace = items_sent + $urandom_range(30, 120);
            end
            if (!playing && $urandom_range(0, 4) != 0)
            begin
                pat = $urandom_range(0, IDLE_PAT - 1);
                if ($urandom_range(0, 2) != 0)
                    load_pattern(pat, ($urandom_range(0, 4) == 0) ? STEPS
                                      : $urandom_range(1, STEPS - 1), $urandom_range(1, 4));
                send_request(pat);
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                // a huge duration landed on the live step, cut it short now and then
                if (playing && step_no != 0 && step_table[cur_pat][step_no - 1].dur > 40
                    && $urandom_range(0, 2) == 0)
                    send_load(int'(cur_pat), step_no - 1, $urandom_range(1, 3),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
                send_tick();
            end
            else
            begin
                it = random_item();
                // keep the idle lock for the last test
                if (it.kind == KIND_REQUEST && playing && it.pattern == IDLE_PAT)
                    it.pattern = it.pattern + 4'(PATTERNS);
                if (it.kind == KIND_TICK)
                    send_tick();
                else
                    send_item(it);
            end
        end
        drain();
    endtask

    // requesting idle mid-play parks the sequencer for good, so this runs last
    task automatic test_idle_lock();
        set_pacing(1'b0);
        if (!playing)
        begin
            send_request(1);
            send_tick();
        end
        send_request(IDLE_PAT);
        repeat (4) send_tick();
        send_request(3);
        send_tick();
        drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: own stall pattern plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : cmd_pacing
        int rx_cycle;
        int holds_done;
        cmd_stall  = 1'b0;
        rx_cycle   = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                cmd_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            rx_cycle++;
            cmd_stall <= (stall_pct != 0)
                         && ((rx_cycle % 7 < 2) || ($urandom_range(0, 99) < stall_pct));
        end
    end

    // ------------------------------------------------------------------
    // command checker: every accepted command against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : cmd_checker
        out_item_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("command with nothing expected: 0x%0h", cmd_item);
                mismatches++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("action", 8'(want.action), 8'(cmd_item.action));
                check_field("out_flag", want.out_flag, cmd_item.out_flag);
                check_field("out_power", want.out_power, cmd_item.out_power);
                check_field("out_freq", want.out_freq, cmd_item.out_freq);
                check_field("last", 8'(want.last), 8'(cmd_item.last));
                cmds_checked++;
            end
        end
    end

    // watchdog: too long with no handshake on either side
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((src_valid && !src_stall) || (cmd_valid && !cmd_stall) || !rst_n)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $error("no item moved for %0d cycles, %0d commands outstanding",
                       quiet, pending_cmds.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        src_item   = '0;
        hold_req   = 0;
        gap_max    = 0;
        burst_left = 0;
        stall_pct  = 0;
        go_idle();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_basic_pattern();
        test_replace();
        test_long_step();
        test_backpressure();
        test_random_traffic();
        test_idle_lock();

        $display("covered %0d input items (%0d in range) and %0d checked commands; %0d patterns played out",
                 items_sent, work_items, cmds_checked, patterns_done);
        $display("incl. replacement, step limit, long receiver hold and the idle lock");
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
